// ===== sv/sap_pkg.sv =====
// Shared types and constants for the slot allocator with limit.
package sap_pkg;

    localparam int FUNC_W     = 1;
    localparam int LIMIT_W    = 8;
    localparam int AFF_W      = 16;
    localparam int PRI_W      = 8;
    localparam int REL_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int GRANT_W    = 4;
    // Widest slot index supported (up to 64 slots)
    localparam int MAX_SLOT_W = 6;

    localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT_RST = 8'd4;

    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_NO_FREE = 2'd2
    } status_t;

    // Table update decided for one request
    typedef struct packed {
        logic                  set_en;
        logic                  clr_en;
        logic [MAX_SLOT_W-1:0] idx;
    } upd_t;

endpackage

// ===== sv/sap_slot_table.sv =====
// Slot table: active bits, stored hint and priority, active count and lowest free slot.
module sap_slot_table #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sap_pkg::upd_t                  upd,
    input  logic [sap_pkg::AFF_W-1:0]      aff_wdata,
    input  logic [sap_pkg::PRI_W-1:0]      pri_wdata,
    output logic [NUM_SLOTS-1:0]           active,
    output logic [$clog2(NUM_SLOTS)-1:0]   active_cnt,
    output logic [$clog2(NUM_SLOTS)-1:0]   free_idx,
    output logic                           free_found
);
    import sap_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] active_next;
    logic [AFF_W-1:0]     affinity_mem [NUM_SLOTS];
    logic [PRI_W-1:0]     priority_mem [NUM_SLOTS];
    logic [SLOT_W-1:0]    wr_idx;

    assign wr_idx = upd.idx[SLOT_W-1:0];

    always_comb
    begin
        active_next = active_reg;
        if (upd.set_en)
        begin
            active_next[wr_idx] = 1'b1;
        end
        else if (upd.clr_en)
        begin
            active_next[wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Store the hint and priority on grant, zero them on release
    always_ff @(posedge clk)
    begin
        if (upd.set_en)
        begin
            affinity_mem[wr_idx] <= aff_wdata;
            priority_mem[wr_idx] <= pri_wdata;
        end
        else if (upd.clr_en)
        begin
            affinity_mem[wr_idx] <= '0;
            priority_mem[wr_idx] <= '0;
        end
    end

    // Count active slots, skipping the reserved slot 0
    always_comb
    begin
        active_cnt = '0;
        for (int i = 1; i < NUM_SLOTS; i++)
        begin
            active_cnt = active_cnt + SLOT_W'(active_reg[i]);
        end
    end

    // Lowest free slot from 1 upward
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 1; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx   = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign active = active_reg;

endmodule

// ===== sv/sap_decide.sv =====
// Request and release decision: effective limit, status, granted slot and table update.
module sap_decide #(
    parameter int NUM_SLOTS = 16
) (
    input  logic [sap_pkg::FUNC_W-1:0]     func,
    input  logic [sap_pkg::LIMIT_W-1:0]    limit_req,
    input  logic [sap_pkg::REL_W-1:0]      release_slot,
    input  logic [sap_pkg::LIMIT_W-1:0]    default_limit,
    input  logic [NUM_SLOTS-1:0]           active,
    input  logic [$clog2(NUM_SLOTS)-1:0]   active_cnt,
    input  logic [$clog2(NUM_SLOTS)-1:0]   free_idx,
    input  logic                           free_found,
    output sap_pkg::status_t               status,
    output logic [sap_pkg::GRANT_W-1:0]    granted_slot,
    output sap_pkg::upd_t                  upd
);
    import sap_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    logic [LIMIT_W-1:0] limit_sel;
    logic               limit_over;
    logic [SLOT_W-1:0]  limit_eff;
    logic               rel_ok;
    logic [SLOT_W-1:0]  rel_idx;

    assign limit_sel  = (limit_req != '0) ? limit_req : default_limit;
    assign limit_over = {1'b0, limit_sel} >= (LIMIT_W + 1)'(NUM_SLOTS);
    // Clamp to the slot count minus one
    assign limit_eff  = limit_over ? SLOT_W'(NUM_SLOTS - 1) : limit_sel[SLOT_W-1:0];

    assign rel_idx = release_slot[SLOT_W-1:0];
    assign rel_ok  = (release_slot != '0)
                  && ({1'b0, release_slot} < (REL_W + 1)'(NUM_SLOTS))
                  && active[rel_idx];

    always_comb
    begin
        status       = ST_OK;
        granted_slot = '0;
        upd          = '0;
        if (func == FUNC_REQUEST)
        begin
            if (limit_eff == '0)
            begin
                status = ST_ILLEGAL;
            end
            else if (active_cnt >= limit_eff || !free_found)
            begin
                status = ST_NO_FREE;
            end
            else
            begin
                status       = ST_OK;
                granted_slot = GRANT_W'(free_idx);
                upd.set_en   = 1'b1;
                upd.idx      = MAX_SLOT_W'(free_idx);
            end
        end
        else
        begin
            if (rel_ok)
            begin
                status     = ST_OK;
                upd.clr_en = 1'b1;
                upd.idx    = MAX_SLOT_W'(rel_idx);
            end
            else
            begin
                status = ST_ILLEGAL;
            end
        end
    end

endmodule

// ===== sv/slot_allocator_with_limit_unit.sv =====
// Slot allocator with limit: top level with request and result registers.
//
// Requests enter on in_valid/in_stall and carry func, limit_req, affinity_req,
// priority_req and release_slot. Results leave on out_valid/out_stall as
// status and granted_slot, one result per request, in order.
// A request is accepted when in_valid is high and in_stall is low.
// It is captured in the input register, settled combinationally by the slot
// table count and lowest-free search, and its result is loaded into the
// output register once the output is free to advance.
// Throughput is one request per cycle while out_stall does not hold a valid
// result; each request sees the table as left by the one before it, since
// the table is updated on the same edge that loads the result.
// When out_stall holds a valid result, the result and the table hold and
// in_stall rises once a request waits in the input register.
// Reset clears all slots to inactive, empties both registers and sets
// default_limit to 4. cfg_we writes default_limit from cfg_wdata.
module slot_allocator_with_limit_unit #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sap_pkg::LIMIT_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [sap_pkg::FUNC_W-1:0]    func,
    input  logic [sap_pkg::LIMIT_W-1:0]   limit_req,
    input  logic [sap_pkg::AFF_W-1:0]     affinity_req,
    input  logic [sap_pkg::PRI_W-1:0]     priority_req,
    input  logic [sap_pkg::REL_W-1:0]     release_slot,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sap_pkg::STATUS_W-1:0]  status,
    output logic [sap_pkg::GRANT_W-1:0]   granted_slot
);
    import sap_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    logic [LIMIT_W-1:0]  default_limit_reg;
    logic                in_valid_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [AFF_W-1:0]    aff_reg;
    logic [PRI_W-1:0]    pri_reg;
    logic [REL_W-1:0]    rel_reg;
    logic                out_valid_reg;
    status_t             status_reg;
    logic [GRANT_W-1:0]  granted_reg;

    logic                advance;
    logic                fire;
    logic                load_in;
    logic [NUM_SLOTS-1:0] active;
    logic [SLOT_W-1:0]   active_cnt;
    logic [SLOT_W-1:0]   free_idx;
    logic                free_found;
    status_t             status_next;
    logic [GRANT_W-1:0]  granted_next;
    upd_t                upd_dec;
    upd_t                upd;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign load_in  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_limit_reg <= DEFAULT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            default_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            func_reg  <= func;
            limit_reg <= limit_req;
            aff_reg   <= affinity_req;
            pri_reg   <= priority_req;
            rel_reg   <= release_slot;
        end
        if (fire)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    sap_decide #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_decide (
        .func         (func_reg),
        .limit_req    (limit_reg),
        .release_slot (rel_reg),
        .default_limit(default_limit_reg),
        .active       (active),
        .active_cnt   (active_cnt),
        .free_idx     (free_idx),
        .free_found   (free_found),
        .status       (status_next),
        .granted_slot (granted_next),
        .upd          (upd_dec)
    );

    // Drop the update unless the request moves to the output register
    always_comb
    begin
        upd        = upd_dec;
        upd.set_en = upd_dec.set_en && fire;
        upd.clr_en = upd_dec.clr_en && fire;
    end

    sap_slot_table #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .aff_wdata (aff_reg),
        .pri_wdata (pri_reg),
        .active    (active),
        .active_cnt(active_cnt),
        .free_idx  (free_idx),
        .free_found(free_found)
    );

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;

endmodule

// ===== sv/sap_checker.sv =====
// Port-level checks for the slot allocator with limit, bound to the top level.
module sap_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [sap_pkg::STATUS_W-1:0]  status,
    input logic [sap_pkg::GRANT_W-1:0]   granted_slot
);
    import sap_pkg::*;

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_slot))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_ILLEGAL || status == ST_NO_FREE)
    else $error("undefined status code");

    // A failed request grants nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_slot == '0)
    else $error("slot granted on failure");

    // Input backs up only behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

endmodule

bind slot_allocator_with_limit_unit sap_checker u_sap_checker (.*);
